@@ rtl/psr_pkg.sv @@
package psr_pkg;

    localparam int SRC_W    = 4;
    localparam int SEQ_W    = 32;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_DELIVERED = 2'd0,
        ST_BACKWARDS = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture request
        logic classify;  // read expected number and its slot
        logic emit_in;   // put the request itself on the output
        logic emit_rej;  // put a reject on the output (status from datapath)
        logic emit_held; // put the held entry at the expected number on the output
        logic hold;      // store request in its slot
        logic advance;   // bump expected number and write it back
        logic last;      // last_of_run for the emitted result
    } psr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic src_ok;
        logic in_order;
        logic bypass;
        logic in_window;
        logic slot_taken;  // slot of request already valid
        logic next_valid;  // held slot at expected number + 1 is valid
        logic run_full;    // this release reaches the window depth
    } psr_stat_t;

endpackage

@@ rtl/psr_if.sv @@
interface psr_in_if;
    logic                          valid;
    logic                          ready;
    logic [psr_pkg::SRC_W-1:0]     source_id;
    logic [psr_pkg::SEQ_W-1:0]     seq_number;
    logic                          bypass_order;
    logic [psr_pkg::HANDLE_W-1:0]  msg_handle;
    modport source (output valid, source_id, seq_number, bypass_order, msg_handle,
                    input ready);
    modport sink (input valid, source_id, seq_number, bypass_order, msg_handle,
                  output ready);
endinterface

interface psr_out_if;
    logic                          valid;
    logic                          ready;
    logic [psr_pkg::STATUS_W-1:0]  status;
    logic [psr_pkg::HANDLE_W-1:0]  out_handle;
    logic [psr_pkg::SRC_W-1:0]     out_source;
    logic [psr_pkg::SEQ_W-1:0]     out_seq;
    logic                          last_of_run;
    modport source (output valid, status, out_handle, out_source, out_seq, last_of_run,
                    input ready);
    modport sink (input valid, status, out_handle, out_source, out_seq, last_of_run,
                  output ready);
endinterface

@@ rtl/psr_datapath.sv @@
module psr_datapath #(
    parameter int NUM_SOURCES = 16,
    parameter int HOLD_DEPTH  = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [psr_pkg::SRC_W-1:0]     source_id,
    input  logic [psr_pkg::SEQ_W-1:0]     seq_number,
    input  logic                          bypass_order,
    input  logic [psr_pkg::HANDLE_W-1:0]  msg_handle,
    input  psr_pkg::psr_cmd_t             cmd,
    output psr_pkg::psr_stat_t            stat,
    output logic [psr_pkg::STATUS_W-1:0]  res_status,
    output logic [psr_pkg::HANDLE_W-1:0]  res_handle,
    output logic [psr_pkg::SRC_W-1:0]     res_source,
    output logic [psr_pkg::SEQ_W-1:0]     res_seq,
    output logic                          res_last
);
    localparam int SRC_IW   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int SLOT_W   = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int SUM_W    = SLOT_W + 2;
    localparam int ENTRIES  = NUM_SOURCES * HOLD_DEPTH;
    localparam int ENT_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(HOLD_DEPTH + 1);
    // slot shift when seq_number has wrapped past 2^32 relative to the expected number
    localparam longint unsigned WRAP_MOD = (64'd1 << 32) % 64'(HOLD_DEPTH);
    localparam int WRAP_ADJ = int'((64'(HOLD_DEPTH) - WRAP_MOD) % 64'(HOLD_DEPTH));

    // expected numbers, their slots and held handles are memories; valid bits are flops
    logic [psr_pkg::SEQ_W-1:0]    exp_mem [NUM_SOURCES];
    logic [SLOT_W-1:0]            eslot_mem [NUM_SOURCES];
    logic [psr_pkg::HANDLE_W-1:0] hnd_mem [ENTRIES];
    logic [ENTRIES-1:0]           held_valid_reg;
    // expected number of a source reads as zero until first written
    logic [NUM_SOURCES-1:0]       exp_init_reg;

    logic [psr_pkg::SRC_W-1:0]    src_reg;
    logic [psr_pkg::SEQ_W-1:0]    seq_reg;
    logic                         byp_reg;
    logic [psr_pkg::HANDLE_W-1:0] hnd_reg;
    logic [psr_pkg::SEQ_W-1:0]    exp_reg;
    logic [SLOT_W-1:0]            eslot_reg;
    logic                         src_ok_reg;
    logic [CNT_W-1:0]             cnt_reg;

    logic [SRC_IW-1:0]            src_idx;
    logic [psr_pkg::SEQ_W-1:0]    seq_gap;
    logic                         wrapped;
    logic [SUM_W-1:0]             req_sum;
    logic [SLOT_W-1:0]            req_slot;
    logic [SLOT_W-1:0]            nxt_slot;
    logic [ENT_W-1:0]             cur_ent;
    logic [ENT_W-1:0]             nxt_ent;
    logic [ENT_W-1:0]             req_ent;

    assign src_idx = SRC_IW'(src_reg);
    assign seq_gap = seq_reg - exp_reg;
    assign wrapped = seq_reg < exp_reg;

    // slot of the request from the slot of the expected number plus the gap
    assign req_sum = SUM_W'(eslot_reg) + seq_gap[SUM_W-1:0]
                   + (wrapped ? SUM_W'(WRAP_ADJ) : SUM_W'(0));

    always_comb
    begin
        if (req_sum >= SUM_W'(2 * HOLD_DEPTH))
            req_slot = SLOT_W'(req_sum - SUM_W'(2 * HOLD_DEPTH));
        else if (req_sum >= SUM_W'(HOLD_DEPTH))
            req_slot = SLOT_W'(req_sum - SUM_W'(HOLD_DEPTH));
        else
            req_slot = SLOT_W'(req_sum);
    end

    // slot of expected number + 1; the 2^32 wrap lands on slot zero
    assign nxt_slot = (exp_reg == '1 || eslot_reg == SLOT_W'(HOLD_DEPTH - 1))
                    ? SLOT_W'(0) : eslot_reg + 1'b1;

    assign cur_ent = ENT_W'(src_idx) * ENT_W'(HOLD_DEPTH) + ENT_W'(eslot_reg);
    assign nxt_ent = ENT_W'(src_idx) * ENT_W'(HOLD_DEPTH) + ENT_W'(nxt_slot);
    assign req_ent = ENT_W'(src_idx) * ENT_W'(HOLD_DEPTH) + ENT_W'(req_slot);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            src_reg <= source_id;
            seq_reg <= seq_number;
            byp_reg <= bypass_order;
            hnd_reg <= msg_handle;
        end
        if (cmd.classify)
        begin
            exp_reg    <= exp_init_reg[src_idx] ? exp_mem[src_idx] : '0;
            eslot_reg  <= exp_init_reg[src_idx] ? eslot_mem[src_idx] : '0;
            src_ok_reg <= 32'(src_reg) < NUM_SOURCES;
        end
        else if (cmd.advance)
        begin
            exp_reg            <= exp_reg + 1'b1;
            eslot_reg          <= nxt_slot;
            exp_mem[src_idx]   <= exp_reg + 1'b1;
            eslot_mem[src_idx] <= nxt_slot;
        end
        if (cmd.hold)
            hnd_mem[req_ent] <= hnd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= '0;
            exp_init_reg   <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (cmd.emit_in)
                cnt_reg <= '0;
            else if (cmd.emit_held)
                cnt_reg <= cnt_reg + 1'b1;
            if (cmd.emit_held)
                held_valid_reg[cur_ent] <= 1'b0;
            else if (cmd.hold)
                held_valid_reg[req_ent] <= 1'b1;
            if (cmd.advance)
                exp_init_reg[src_idx] <= 1'b1;
        end
    end

    always_comb
    begin
        stat.src_ok     = src_ok_reg;
        stat.in_order   = seq_gap == '0;
        stat.bypass     = byp_reg;
        stat.in_window  = seq_gap <= psr_pkg::SEQ_W'(HOLD_DEPTH);
        stat.slot_taken = held_valid_reg[req_ent];
        stat.next_valid = held_valid_reg[nxt_ent];
        stat.run_full   = cnt_reg >= CNT_W'(HOLD_DEPTH - 1);
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.emit_in || cmd.emit_rej)
        begin
            res_status <= cmd.emit_in ? psr_pkg::ST_DELIVERED
                        : (wrapped ? psr_pkg::ST_BACKWARDS : psr_pkg::ST_OVERFLOW);
            res_handle <= hnd_reg;
            res_source <= src_reg;
            res_seq    <= seq_reg;
            res_last   <= cmd.last;
        end
        else if (cmd.emit_held)
        begin
            res_status <= psr_pkg::ST_DELIVERED;
            res_handle <= hnd_mem[cur_ent];
            res_source <= src_reg;
            res_seq    <= exp_reg;
            res_last   <= cmd.last;
        end
    end
endmodule

@@ rtl/psr_ctrl.sv @@
module psr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  psr_pkg::psr_stat_t stat,
    output psr_pkg::psr_cmd_t  cmd
);
    typedef enum logic [1:0] {
        S_IDLE,
        S_CLASSIFY,
        S_DECIDE,
        S_RELEASE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    // result register empty, or emptied at this edge
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                cmd.classify = 1'b1;
                state_next   = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (!stat.src_ok)
                    state_next = S_IDLE;
                else if (!stat.in_order && !stat.bypass && stat.in_window)
                begin
                    cmd.hold   = !stat.slot_taken;
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (stat.in_order)
                    begin
                        cmd.emit_in = 1'b1;
                        cmd.advance = 1'b1;
                        cmd.last    = !stat.next_valid;
                        state_next  = stat.next_valid ? S_RELEASE : S_IDLE;
                    end
                    else if (stat.bypass)
                    begin
                        cmd.emit_in = 1'b1;
                        cmd.last    = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        cmd.emit_rej = 1'b1;
                        cmd.last     = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
            end
            S_RELEASE:
            begin
                if (out_free)
                begin
                    cmd.emit_held  = 1'b1;
                    cmd.advance    = 1'b1;
                    cmd.last       = !stat.next_valid || stat.run_full;
                    out_valid_next = 1'b1;
                    state_next     = (!stat.next_valid || stat.run_full) ? S_IDLE : S_RELEASE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

@@ rtl/per_source_sequence_reorder.sv @@
// Per-source sequence reorder: in-order, bypass, held and rejected requests.
// Steps: the accepted request's expected number is read, then the decide writes
// the result register; released results follow one per cycle while out_ready holds.
// One request at a time; a result waiting at the output stalls the decide.
// Reset: asynchronous active-low; expected numbers read as zero, held window empty.
module per_source_sequence_reorder #(
    parameter int NUM_SOURCES = 16,
    parameter int HOLD_DEPTH  = 8
) (
    input logic       clk,
    input logic       rst_n,
    psr_in_if.sink    in_ch,
    psr_out_if.source out_ch
);
    psr_pkg::psr_cmd_t  cmd;
    psr_pkg::psr_stat_t stat;
    logic               last_raw;

    // Controller sequences classify, hold and the release run.
    psr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath holds expected numbers, held window and the result register.
    psr_datapath #(
        .NUM_SOURCES (NUM_SOURCES),
        .HOLD_DEPTH  (HOLD_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .source_id    (in_ch.source_id),
        .seq_number   (in_ch.seq_number),
        .bypass_order (in_ch.bypass_order),
        .msg_handle   (in_ch.msg_handle),
        .cmd          (cmd),
        .stat         (stat),
        .res_status   (out_ch.status),
        .res_handle   (out_ch.out_handle),
        .res_source   (out_ch.out_source),
        .res_seq      (out_ch.out_seq),
        .res_last     (last_raw)
    );

    // The end of a release run is found by looking ahead at the next slot when each
    // result is emitted, or when the run reaches the window depth.
    assign out_ch.last_of_run = last_raw;
endmodule
